@@ hw/rtl/mi3_pkg.sv @@
// Package for the 3x3 matrix inverse: widths, pipeline stage types and the
// restoring divide step. No dependencies.
`default_nettype none
package mi3_pkg;
   localparam int NumEnt  = 9;
   localparam int EW      = 16;  // input entry
   localparam int PW      = 32;  // 16x16 product
   localparam int AW      = 33;  // adjugate entry
   localparam int MW      = 49;  // row-0 entry times cofactor
   localparam int DETW    = 51;  // determinant
   localparam int DW      = 50;  // |det|
   localparam int NW      = 48;  // |adj| << 16
   localparam int QW      = 32;  // quotient magnitude
   localparam int RW      = 82;  // room for |det| << 31 plus borrow
   localparam int FracW   = 16;

   typedef struct packed {
      logic [NW-1:0] rem;
      logic [QW-1:0] q;
      logic          neg;
      logic          ovf;
   } lane_type;

   typedef struct packed {
      logic                     valid;
      logic                     sing;
      logic [DW-1:0]            d;
      lane_type [NumEnt-1:0]    lane;
   } stage_type;

   typedef struct packed {
      logic                     sing;
      logic [NumEnt-1:0][31:0]  r;
   } result_type;

   // One restoring step: try to take d << sh from the remainder.
   function automatic lane_type div_step(lane_type li, logic [DW-1:0] d, int sh);
      logic [RW-1:0] diff;
      lane_type      lo;
      lo   = li;
      diff = {{(RW-NW){1'b0}}, li.rem} - ({{(RW-DW){1'b0}}, d} << sh);
      if (!diff[RW-1]) begin
         lo.rem = diff[NW-1:0];
         lo.q   = li.q | (QW'(1) << sh);
      end
      return lo;
   endfunction
endpackage
`default_nettype wire

@@ hw/rtl/matrix_inverse_3x3_top.sv @@
// 3x3 matrix inverse, adjugate over determinant, Q15.16 output.
// Depends on mi3_pkg.
`default_nettype none
// One matrix per beat in, one inverse per beat out. Throughput is one matrix
// per clock while the output queue has room. The pipeline registers the
// products, the cofactor subtracts, the row-0 products, the determinant sum,
// and the magnitudes and overflow check, then 32 stages of a restoring divider
// (one quotient bit per stage for all nine entries in parallel). Results drain
// into a two-beat output queue; the whole pipeline advances while the queue
// has room, so input is taken while a finished result waits. A zero
// determinant gives singular=1 and all entries zero; quotients beyond the
// signed 32-bit range saturate.
module matrix_inverse_3x3_top (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [143:0] req_tdata,   // e00,e01,e02,e10,e11,e12,e20,e21,e22 (16b each)
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [287:0] rsp_tdata,   // r00,r01,r02,r10,r11,r12,r20,r21,r22 (32b each)
   output logic [0:0]   rsp_tuser    // singular
);
   import mi3_pkg::*;

   localparam int NStep = QW;

   logic en;

   // stage 1: products
   logic                   v1_ff;
   logic signed [PW-1:0]   p1_ff [18];
   logic signed [EW-1:0]   r0_1_ff [3];
   // stage 2: adjugate
   logic                   v2_ff;
   logic signed [AW-1:0]   adj2_ff [NumEnt];
   logic signed [EW-1:0]   r0_2_ff [3];
   // stage 3: row-0 terms
   logic                   v3_ff;
   logic signed [MW-1:0]   m3_ff [3];
   logic signed [AW-1:0]   adj3_ff [NumEnt];
   // stage 4: determinant
   logic                   v4_ff;
   logic signed [DETW-1:0] det4_ff;
   logic signed [AW-1:0]   adj4_ff [NumEnt];
   // divider stages
   stage_type dv_ff [NStep+1];
   stage_type dv_in [NStep+1];

   logic signed [EW-1:0] e [NumEnt];
   always_comb begin
      for (int k = 0; k < NumEnt; k++) begin
         e[k] = req_tdata[EW*k +: EW];
      end
   end

   // cofactor product pairs: adj[k] = p[2k] - p[2k+1]
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
      if (en) begin
         p1_ff[0]  <= e[4] * e[8];  p1_ff[1]  <= e[7] * e[5];
         p1_ff[2]  <= e[7] * e[2];  p1_ff[3]  <= e[1] * e[8];
         p1_ff[4]  <= e[1] * e[5];  p1_ff[5]  <= e[4] * e[2];
         p1_ff[6]  <= e[5] * e[6];  p1_ff[7]  <= e[8] * e[3];
         p1_ff[8]  <= e[8] * e[0];  p1_ff[9]  <= e[2] * e[6];
         p1_ff[10] <= e[2] * e[3];  p1_ff[11] <= e[5] * e[0];
         p1_ff[12] <= e[3] * e[7];  p1_ff[13] <= e[6] * e[4];
         p1_ff[14] <= e[6] * e[1];  p1_ff[15] <= e[0] * e[7];
         p1_ff[16] <= e[0] * e[4];  p1_ff[17] <= e[3] * e[1];
         r0_1_ff[0] <= e[0];
         r0_1_ff[1] <= e[1];
         r0_1_ff[2] <= e[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (en) begin
         for (int k = 0; k < NumEnt; k++) begin
            adj2_ff[k] <= AW'(p1_ff[2*k]) - AW'(p1_ff[2*k+1]);
         end
         r0_2_ff <= r0_1_ff;
         // det = a00*adj0 + a01*adj3 + a02*adj6
         m3_ff[0] <= MW'(r0_2_ff[0]) * MW'(adj2_ff[0]);
         m3_ff[1] <= MW'(r0_2_ff[1]) * MW'(adj2_ff[3]);
         m3_ff[2] <= MW'(r0_2_ff[2]) * MW'(adj2_ff[6]);
         adj3_ff  <= adj2_ff;
         det4_ff  <= DETW'(m3_ff[0]) + DETW'(m3_ff[1]) + DETW'(m3_ff[2]);
         adj4_ff  <= adj3_ff;
      end
   end

   // stage 5: signs, magnitudes, overflow (|adj|<<16 >= |det|<<32)
   logic [DETW-1:0] det_abs;
   logic [AW-1:0]   adj_abs [NumEnt];
   always_comb begin
      det_abs = det4_ff[DETW-1] ? DETW'(-det4_ff) : DETW'(det4_ff);
      dv_in[0].valid = v4_ff;
      dv_in[0].sing  = (det4_ff == '0);
      dv_in[0].d     = det_abs[DW-1:0];
      for (int k = 0; k < NumEnt; k++) begin
         adj_abs[k] = adj4_ff[k][AW-1] ? AW'(-adj4_ff[k]) : AW'(adj4_ff[k]);
         dv_in[0].lane[k].rem = {adj_abs[k][NW-FracW-1:0], {FracW{1'b0}}};
         dv_in[0].lane[k].q   = '0;
         dv_in[0].lane[k].neg = adj4_ff[k][AW-1] ^ det4_ff[DETW-1];
         dv_in[0].lane[k].ovf = {{(DW-(NW-QW)){1'b0}}, dv_in[0].lane[k].rem[NW-1:QW]}
                                >= det_abs[DW-1:0];
      end
   end

   for (genvar s = 0; s < NStep; s++) begin : g_div
      always_comb begin
         dv_in[s+1] = dv_ff[s];
         for (int k = 0; k < NumEnt; k++) begin
            dv_in[s+1].lane[k] = div_step(dv_ff[s].lane[k], dv_ff[s].d, NStep-1-s);
         end
      end
   end

   for (genvar s = 0; s <= NStep; s++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[s].valid <= 1'b0;
         end else if (en) begin
            dv_ff[s] <= dv_in[s];
         end
      end
   end

   // saturate and sign the quotients
   result_type fin;
   always_comb begin
      fin.sing = dv_ff[NStep].sing;
      for (int k = 0; k < NumEnt; k++) begin
         if (dv_ff[NStep].sing) begin
            fin.r[k] = '0;
         end else if (!dv_ff[NStep].lane[k].neg) begin
            if (dv_ff[NStep].lane[k].ovf || dv_ff[NStep].lane[k].q[QW-1]) begin
               fin.r[k] = 32'h7FFF_FFFF;
            end else begin
               fin.r[k] = dv_ff[NStep].lane[k].q;
            end
         end else begin
            if (dv_ff[NStep].lane[k].ovf || dv_ff[NStep].lane[k].q > 32'h8000_0000) begin
               fin.r[k] = 32'h8000_0000;
            end else begin
               fin.r[k] = 32'(-dv_ff[NStep].lane[k].q);
            end
         end
      end
   end

   // two-beat output queue; pipeline advances while it has room
   result_type q_ff [2];
   logic [1:0] cnt_ff;
   logic       wr_ff, rd_ff;
   logic       push, pop;

   assign en    = (cnt_ff != 2'd2);
   assign push  = en && dv_ff[NStep].valid;
   assign pop   = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
      end
      if (push) q_ff[wr_ff] <= fin;
   end

   assign req_tready   = en;
   assign rsp_tvalid   = (cnt_ff != 2'd0);
   assign rsp_tdata    = q_ff[rd_ff].r;
   assign rsp_tuser[0] = q_ff[rd_ff].sing;
endmodule
`default_nettype wire

@@ hw/rtl/mi3_checker.sv @@
// Port-level checks for matrix_inverse_3x3_top, with the bind.
// No package dependencies.
`default_nettype none
module mi3_checker (
   input wire         clock,
   input wire         reset,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [287:0] rsp_tdata,
   input wire [0:0]   rsp_tuser
);
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("singular beat with nonzero entries");
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");
endmodule

bind matrix_inverse_3x3_top mi3_checker u_mi3_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
